@@ rtl/u2t_pkg.sv @@
// Shared types and constants for the UTF-8 text to tile writer.
// Holds the character code table and the lookup result type.
// No dependencies; compiled first.
package u2t_pkg;

  localparam int BYTE_W      = 8;
  localparam int CODE_W      = 16;
  localparam int TILE_W      = 11;
  localparam int POS_W       = 7;
  localparam int GLYPH_COUNT = 96;
  localparam int GLYPH_IDX_W = 7;

  localparam logic [TILE_W-1:0] TILE_BASE_RESET = 11'h5A0;
  localparam logic [2:0]        LEAD_TAG        = 3'b110;
  localparam logic [BYTE_W-1:0] NEWLINE_BYTE    = 8'h0A;

  // Character codes in tile order; two-byte entries hold {lead, second}.
  localparam logic [CODE_W-1:0] GLYPH_CODES [GLYPH_COUNT] = '{
    16'h0020, 16'h0021, 16'h003F, 16'h0023, 16'h0024, 16'h0025, 16'h00A8, 16'h0026,
    16'h002A, 16'h0028, 16'h0029, 16'h002D, 16'h002B, 16'h002C, 16'h002E, 16'h002F,
    16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
    16'h0038, 16'h0039, 16'h003A, 16'h003B, 16'hC3A1, 16'hC3A9, 16'hC3AD, 16'hC3B3,
    16'hC3BA, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
    16'h0048, 16'h0049, 16'h004A, 16'h004B, 16'h004C, 16'h004D, 16'h004E, 16'h004F,
    16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
    16'h0058, 16'h0059, 16'h005A, 16'h005B, 16'h005C, 16'h005D, 16'hC387, 16'hC3A7,
    16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067, 16'h0068,
    16'h0069, 16'h006A, 16'h006B, 16'h006C, 16'h006D, 16'h006E, 16'h006F, 16'h0070,
    16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077, 16'h0078,
    16'h0079, 16'h007A, 16'hC3A3, 16'hC3B5, 16'hC3A2, 16'hC3AA, 16'hC3B4, 16'hC3B1
  };

  // Result of one table search.
  typedef struct packed {
    logic                   hit;
    logic [GLYPH_IDX_W-1:0] index;
  } glyph_match_t;

endpackage

@@ rtl/u2t_ifs.sv @@
// Valid/ready channel interfaces for the text byte input and the tile write output.
// Depends on u2t_pkg for field widths.
interface u2t_in_if;
  logic                          valid;
  logic                          ready;
  logic [u2t_pkg::BYTE_W-1:0]    text_byte;
  logic                          start_of_text;
  logic [u2t_pkg::POS_W-1:0]     start_col;
  logic [u2t_pkg::POS_W-1:0]     start_row;

  modport source (output valid, text_byte, start_of_text, start_col, start_row,
                  input ready);
  modport sink (input valid, text_byte, start_of_text, start_col, start_row,
                output ready);
endinterface

interface u2t_out_if;
  logic                          valid;
  logic                          ready;
  logic [u2t_pkg::TILE_W-1:0]    tile_number;
  logic [u2t_pkg::POS_W-1:0]     cell_col;
  logic [u2t_pkg::POS_W-1:0]     cell_row;
  logic                          was_mapped;

  modport source (output valid, tile_number, cell_col, cell_row, was_mapped,
                  input ready);
  modport sink (input valid, tile_number, cell_col, cell_row, was_mapped,
                output ready);
endinterface

@@ rtl/u2t_glyph_lookup.sv @@
// Combinational search of the character code table.
// Depends on u2t_pkg for the table and the match type.
module u2t_glyph_lookup (
  input  logic [u2t_pkg::CODE_W-1:0] code,
  output u2t_pkg::glyph_match_t      match
);
  import u2t_pkg::*;

  logic [GLYPH_COUNT-1:0] hit_vec;
  logic [GLYPH_IDX_W-1:0] index_or;

  // Compare against every entry; codes are unique, so the indexes can be ORed.
  always_comb begin
    index_or = '0;
    for (int i = 0; i < GLYPH_COUNT; i++) begin
      hit_vec[i] = (code == GLYPH_CODES[i]);
      if (hit_vec[i]) begin
        index_or = index_or | GLYPH_IDX_W'(i);
      end
    end
  end

  assign match.hit   = |hit_vec;
  assign match.index = index_or;

endmodule

@@ rtl/utf8_text_to_tile_writer.sv @@
// UTF-8 text to tile-map writer: one tile write per printed character.
// A byte accepted into the input stage register is decoded by the
// combinational table search; its tile write goes to the result register.
// Throughput: one text byte per cycle while the result register is free.
// Reset (synchronous, rst_n low): cursor, line start and pending lead byte
// clear to zero, tile base returns to 0x5A0, and both pipeline stages empty.
module utf8_text_to_tile_writer #(
  parameter int COORD_BITS = 7
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [u2t_pkg::TILE_W-1:0] cfg_wdata,
  u2t_in_if.sink                     in_ch,
  u2t_out_if.source                  out_ch
);
  import u2t_pkg::*;

  // Input stage register.
  logic                  s1_valid_r;
  logic [BYTE_W-1:0]     s1_byte_r;
  logic                  s1_sot_r;
  logic [POS_W-1:0]      s1_col_r;
  logic [POS_W-1:0]      s1_row_r;

  // Decoder state.
  logic [TILE_W-1:0]     tile_base_r;
  logic [BYTE_W-1:0]     lead_byte_r, lead_byte_nxt;
  logic                  lead_pending_r, lead_pending_nxt;
  logic [COORD_BITS-1:0] cursor_col_r, cursor_col_nxt;
  logic [COORD_BITS-1:0] cursor_row_r, cursor_row_nxt;
  logic [COORD_BITS-1:0] line_col_r, line_col_nxt;

  // Result register.
  logic                  out_valid_r, out_valid_nxt;
  logic [TILE_W-1:0]     out_tile_r;
  logic [POS_W-1:0]      out_col_r;
  logic [POS_W-1:0]      out_row_r;
  logic                  out_mapped_r;

  logic                  can_out;
  logic                  proc;
  logic                  in_fire;
  logic [COORD_BITS-1:0] col0, row0;
  logic                  pend0;
  logic                  emit;
  logic                  is_lead;
  logic [CODE_W-1:0]     code;
  glyph_match_t          match;

  // Handshake: the result register frees when empty or taken.
  assign can_out      = !out_valid_r || out_ch.ready;
  assign proc         = s1_valid_r && can_out;
  assign in_ch.ready  = !s1_valid_r || can_out;
  assign in_fire      = in_ch.valid && in_ch.ready;

  // Start-of-text override of the cursor ahead of the byte itself.
  assign col0    = s1_sot_r ? COORD_BITS'(s1_col_r) : cursor_col_r;
  assign row0    = s1_sot_r ? COORD_BITS'(s1_row_r) : cursor_row_r;
  assign pend0   = s1_sot_r ? 1'b0 : lead_pending_r;
  assign is_lead = (s1_byte_r[BYTE_W-1:BYTE_W-3] == LEAD_TAG);
  assign code    = pend0 ? {lead_byte_r, s1_byte_r} : {{(CODE_W-BYTE_W){1'b0}}, s1_byte_r};

  u2t_glyph_lookup u_lookup (
    .code  (code),
    .match (match)
  );

  // Byte decoding and cursor update.
  always_comb begin
    lead_byte_nxt    = lead_byte_r;
    lead_pending_nxt = lead_pending_r;
    cursor_col_nxt   = cursor_col_r;
    cursor_row_nxt   = cursor_row_r;
    line_col_nxt     = line_col_r;
    emit             = 1'b0;
    if (proc) begin
      cursor_col_nxt = col0;
      cursor_row_nxt = row0;
      if (s1_sot_r) begin
        line_col_nxt     = col0;
        lead_pending_nxt = 1'b0;
        lead_byte_nxt    = '0;
      end
      if (pend0) begin
        emit             = 1'b1;
        lead_pending_nxt = 1'b0;
        lead_byte_nxt    = '0;
      end else if (is_lead) begin
        lead_pending_nxt = 1'b1;
        lead_byte_nxt    = s1_byte_r;
      end else if (s1_byte_r == NEWLINE_BYTE) begin
        cursor_col_nxt = s1_sot_r ? col0 : line_col_r;
        cursor_row_nxt = row0 + COORD_BITS'(1);
      end else begin
        emit = 1'b1;
      end
      if (emit) begin
        cursor_col_nxt = col0 + COORD_BITS'(1);
      end
    end
  end

  assign out_valid_nxt = proc ? emit : (out_valid_r && !out_ch.ready);

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      tile_base_r    <= TILE_BASE_RESET;
      lead_byte_r    <= '0;
      lead_pending_r <= 1'b0;
      cursor_col_r   <= '0;
      cursor_row_r   <= '0;
      line_col_r     <= '0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      out_valid_r    <= out_valid_nxt;
      if (cfg_we) begin
        tile_base_r <= cfg_wdata;
      end
      lead_byte_r    <= lead_byte_nxt;
      lead_pending_r <= lead_pending_nxt;
      cursor_col_r   <= cursor_col_nxt;
      cursor_row_r   <= cursor_row_nxt;
      line_col_r     <= line_col_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_ch.text_byte;
      s1_sot_r  <= in_ch.start_of_text;
      s1_col_r  <= in_ch.start_col;
      s1_row_r  <= in_ch.start_row;
    end
    if (proc && emit) begin
      out_tile_r   <= tile_base_r + (match.hit ? TILE_W'(match.index) : '0);
      out_col_r    <= POS_W'(col0);
      out_row_r    <= POS_W'(row0);
      out_mapped_r <= match.hit;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.tile_number = out_tile_r;
  assign out_ch.cell_col    = out_col_r;
  assign out_ch.cell_row    = out_row_r;
  assign out_ch.was_mapped  = out_mapped_r;

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result valid after reset");

  // A lead byte with nothing pending is held for the next byte.
  a_lead_held: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && !pend0 && is_lead) |=> lead_pending_r)
    else $error("lead byte not held");

  // A new result only appears after a byte was processed.
  a_rise_from_proc: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(proc))
    else $error("result without a processed byte");

  // A registered byte is kept while the result side is blocked.
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !can_out) |=> s1_valid_r)
    else $error("input stage lost a byte");

endmodule

@@ tb/sv/tile_write_checker.sv @@
// Watches the text word and tile write channels of the text to tile writer,
// predicts every tile write and compares it with what the block sends.
// Depends on u2t_pkg and the channel interfaces in u2t_ifs.sv.
module tile_write_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [u2t_pkg::TILE_W-1:0] cfg_wdata,
  u2t_in_if                          in_mon,
  u2t_out_if                         out_mon,
  output int                         fail_count,
  output int                         pending_writes
);
  import u2t_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [TILE_W-1:0] tile;
    logic [POS_W-1:0]  col;
    logic [POS_W-1:0]  row;
    logic              mapped;
  } tile_write_t;

  // Font order of the loaded tiles; two-byte letters are stored as {lead, second}.
  localparam logic [15:0] FONT_ORDER [96] = '{
    16'h0020, 16'h0021, 16'h003F, 16'h0023, 16'h0024, 16'h0025, 16'h00A8, 16'h0026,
    16'h002A, 16'h0028, 16'h0029, 16'h002D, 16'h002B, 16'h002C, 16'h002E, 16'h002F,
    16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
    16'h0038, 16'h0039, 16'h003A, 16'h003B, 16'hC3A1, 16'hC3A9, 16'hC3AD, 16'hC3B3,
    16'hC3BA, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
    16'h0048, 16'h0049, 16'h004A, 16'h004B, 16'h004C, 16'h004D, 16'h004E, 16'h004F,
    16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
    16'h0058, 16'h0059, 16'h005A, 16'h005B, 16'h005C, 16'h005D, 16'hC387, 16'hC3A7,
    16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067, 16'h0068,
    16'h0069, 16'h006A, 16'h006B, 16'h006C, 16'h006D, 16'h006E, 16'h006F, 16'h0070,
    16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077, 16'h0078,
    16'h0079, 16'h007A, 16'hC3A3, 16'hC3B5, 16'hC3A2, 16'hC3AA, 16'hC3B4, 16'hC3B1
  };

  // Predicted state of the block.
  logic [TILE_W-1:0] font_base;
  logic [BYTE_W-1:0] held_lead;
  logic              lead_waiting;
  logic [POS_W-1:0]  cur_col;
  logic [POS_W-1:0]  cur_row;
  logic [POS_W-1:0]  margin_col;
  tile_write_t       write_queue[$];
  int                mismatches = 0;

  // Queues one tile write for a character code at the cursor and moves right.
  task automatic place_glyph(input logic [15:0] code);
    tile_write_t w;
    logic [6:0]  slot;
    logic        hit;
    slot = '0;
    hit  = 1'b0;
    for (int i = 0; i < 96; i++) begin
      if (!hit && FONT_ORDER[i] == code) begin
        hit  = 1'b1;
        slot = i[6:0];
      end
    end
    w.tile   = font_base + {4'b0, slot};
    w.col    = cur_col;
    w.row    = cur_row;
    w.mapped = hit;
    write_queue.push_back(w);
    cur_col = cur_col + POS_W'(1);
  endtask

  // Applies one accepted text word to the predicted state.
  task automatic predict_word(input logic [BYTE_W-1:0] ch, input logic sot,
                              input logic [POS_W-1:0] col, input logic [POS_W-1:0] row);
    if (sot) begin
      cur_col      = col;
      cur_row      = row;
      margin_col   = col;
      lead_waiting = 1'b0;
      held_lead    = '0;
    end
    if (lead_waiting) begin
      // The byte after a lead is always the second byte, even a newline.
      lead_waiting = 1'b0;
      place_glyph({held_lead, ch});
      held_lead = '0;
    end else if (ch[7:5] == LEAD_TAG) begin
      held_lead    = ch;
      lead_waiting = 1'b1;
    end else if (ch == NEWLINE_BYTE) begin
      cur_col = margin_col;
      cur_row = cur_row + POS_W'(1);
    end else begin
      place_glyph({8'h00, ch});
    end
  endtask

  task automatic check_field(input string fname, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
      mismatches++;
    end
  endtask

  // Output words are checked before input words are predicted; a word taken
  // at this edge cannot produce a write at the same edge.
  always @(posedge clk) begin
    tile_write_t want;
    if (!rst_n) begin
      font_base    = TILE_BASE_RESET;
      held_lead    = '0;
      lead_waiting = 1'b0;
      cur_col      = '0;
      cur_row      = '0;
      margin_col   = '0;
      write_queue.delete();
    end else begin
      if (cfg_we) begin
        font_base = cfg_wdata;
      end
      if (out_mon.valid && out_mon.ready) begin
        if (write_queue.size() == 0) begin
          $display("%0t: unexpected tile write, expected none, got tile %0d at (%0d,%0d)",
                   $time, out_mon.tile_number, out_mon.cell_col, out_mon.cell_row);
          mismatches++;
        end else begin
          want = write_queue.pop_front();
          check_field("tile_number", int'(want.tile), int'(out_mon.tile_number));
          check_field("cell_col", int'(want.col), int'(out_mon.cell_col));
          check_field("cell_row", int'(want.row), int'(out_mon.cell_row));
          check_field("was_mapped", int'(want.mapped), int'(out_mon.was_mapped));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_word(in_mon.text_byte, in_mon.start_of_text, in_mon.start_col,
                     in_mon.start_row);
      end
    end
    pending_writes = write_queue.size();
    fail_count     = mismatches;
  end

endmodule

@@ tb/sv/tb_utf8_text_to_tile_writer.sv @@
// Top of the text to tile writer testbench: clock, reset, text stimulus,
// receiver stalls, tile base writes, watchdog and final verdict.
// Depends on u2t_pkg, u2t_ifs.sv, the block itself and tile_write_checker.
module tb_utf8_text_to_tile_writer;
  import u2t_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 150;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 205;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [TILE_W-1:0] cfg_wdata;
  int                fail_count;
  int                pending_writes;
  int                idle_pct;
  int                stall_pct;
  int                words_sent;
  int                quiet_cycles;
  logic              hold_req;
  logic              hold_done = 1'b0;

  u2t_in_if  in_bus();
  u2t_out_if out_bus();

  utf8_text_to_tile_writer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_bus),
    .out_ch    (out_bus)
  );

  tile_write_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_mon         (in_bus),
    .out_mon        (out_bus),
    .fail_count     (fail_count),
    .pending_writes (pending_writes)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Offers one text word from a falling edge and returns at the falling edge
  // after it is taken, with valid still high.
  task automatic send_word(input logic [BYTE_W-1:0] ch, input logic sot,
                           input logic [POS_W-1:0] col, input logic [POS_W-1:0] row);
    while ($urandom_range(99) < idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid         = 1'b1;
    in_bus.text_byte     = ch;
    in_bus.start_of_text = sot;
    in_bus.start_col     = col;
    in_bus.start_row     = row;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
    words_sent++;
  endtask

  // Sends one piece of text: a printable byte, a byte pair, a newline or a stray byte.
  task automatic send_text_run();
    logic [BYTE_W-1:0] seconds [13];
    logic [BYTE_W-1:0] lead;
    logic [BYTE_W-1:0] tail;
    int                pick;
    seconds = '{8'hA1, 8'hA9, 8'hAD, 8'hB3, 8'hBA, 8'h87, 8'hA7,
                8'hA3, 8'hB5, 8'hA2, 8'hAA, 8'hB4, 8'hB1};
    pick = $urandom_range(99);
    if (pick < 45) begin
      send_word(8'($urandom_range(8'h7E, 8'h20)), $urandom_range(99) < 4,
                7'($urandom), 7'($urandom));
    end else if (pick < 65) begin
      lead = ($urandom_range(99) < 80) ? 8'hC3 : 8'($urandom_range(8'hDF, 8'hC0));
      tail = ($urandom_range(99) < 60) ? seconds[$urandom_range(12)]
                                       : 8'($urandom_range(255));
      send_word(lead, $urandom_range(99) < 4, 7'($urandom), 7'($urandom));
      send_word(tail, $urandom_range(99) < 4, 7'($urandom), 7'($urandom));
    end else if (pick < 78) begin
      send_word(NEWLINE_BYTE, $urandom_range(99) < 4, 7'($urandom), 7'($urandom));
    end else begin
      send_word(8'($urandom_range(255)), $urandom_range(99) < 4,
                7'($urandom), 7'($urandom));
    end
  endtask

  // Writes the tile base once every write has come out and the pipe is empty.
  task automatic set_tile_base(input logic [TILE_W-1:0] value);
    in_bus.valid = 1'b0;
    while (pending_writes != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  always begin
    @(negedge clk);
    if (hold_req && !hold_done) begin
      out_bus.ready = 1'b0;
      repeat (HOLD_CYCLES - 1) @(negedge clk);
      hold_done = 1'b1;
    end else begin
      out_bus.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog on cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("utf8_text_to_tile_writer verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [TILE_W-1:0] bases [PHASES];
    int                idle_mix [4];
    int                stall_mix [4];
    int                target;
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    in_bus.valid         = 1'b0;
    in_bus.text_byte     = '0;
    in_bus.start_of_text = 1'b0;
    in_bus.start_col     = '0;
    in_bus.start_row     = '0;
    idle_pct             = 0;
    stall_pct            = 0;
    words_sent           = 0;
    hold_req             = 1'b0;
    bases     = '{11'd0, 11'd1952, 11'd2047, 11'($urandom_range(1952)),
                  TILE_BASE_RESET, 11'd1, 11'($urandom_range(1952)), 11'd1024};
    idle_mix  = '{0, 56, 0, 23};
    stall_mix = '{0, 0, 56, 23};

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed text at the reset tile base, no idling.
    send_word(8'h41, 1'b1, 7'd0, 7'd0);
    send_word(8'h20, 1'b0, 7'd0, 7'd0);
    send_word(8'h7A, 1'b0, 7'd0, 7'd0);
    send_word(8'h00, 1'b0, 7'd0, 7'd0);
    send_word(8'hFF, 1'b0, 7'd0, 7'd0);
    send_word(8'hA8, 1'b0, 7'd0, 7'd0);
    send_word(8'h80, 1'b0, 7'd0, 7'd0);
    // Accented letter, then a lead followed by a newline as its second byte.
    send_word(8'hC3, 1'b0, 7'd0, 7'd0);
    send_word(8'hA1, 1'b0, 7'd0, 7'd0);
    send_word(8'hC3, 1'b0, 7'd0, 7'd0);
    send_word(NEWLINE_BYTE, 1'b0, 7'd0, 7'd0);
    // Unknown pair still takes both bytes and prints one space.
    send_word(8'hDF, 1'b0, 7'd0, 7'd0);
    send_word(8'hFF, 1'b0, 7'd0, 7'd0);
    send_word(NEWLINE_BYTE, 1'b0, 7'd0, 7'd0);
    // A dangling lead is dropped by the next start of text, at the far corner.
    send_word(8'hC0, 1'b0, 7'd0, 7'd0);
    send_word(8'h61, 1'b1, 7'd127, 7'd127);
    send_word(8'h62, 1'b0, 7'd0, 7'd0);
    send_word(NEWLINE_BYTE, 1'b0, 7'd0, 7'd0);
    send_word(8'hC3, 1'b0, 7'd0, 7'd0);
    send_word(8'hB1, 1'b0, 7'd0, 7'd0);
    send_word(8'hE0, 1'b0, 7'd0, 7'd0);
    send_word(NEWLINE_BYTE, 1'b1, 7'h55, 7'h2A);
    send_word(8'hC3, 1'b0, 7'd0, 7'd0);
    send_word(8'h87, 1'b0, 7'd0, 7'd0);
    send_word(8'h7F, 1'b0, 7'd0, 7'd0);

    // Random text in phases, each with its own tile base and one of four idling mixes.
    for (int p = 0; p < PHASES; p++) begin
      set_tile_base(bases[p]);
      idle_pct  = idle_mix[p % 4];
      stall_pct = stall_mix[p % 4];
      if (p == 4) begin
        hold_req = 1'b1;
      end
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) send_text_run();
    end
    in_bus.valid = 1'b0;

    while (pending_writes != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("utf8_text_to_tile_writer verification clean");
    end else begin
      $display("utf8_text_to_tile_writer verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/u2t_pkg.sv
rtl/u2t_ifs.sv
rtl/u2t_glyph_lookup.sv
rtl/utf8_text_to_tile_writer.sv
tb/sv/tile_write_checker.sv
tb/sv/tb_utf8_text_to_tile_writer.sv
